/* rtl/core/cc20rng_pkg.sv */
// Shared types and constants for the ChaCha20 feedback random generator.
package cc20rng_pkg;

  localparam int WORD_W        = 32;
  localparam int OUT_W         = 31;
  localparam int WORD_COUNT    = 16;
  localparam int IDX_W         = 4;
  localparam int POS_W         = 5;
  localparam int DOUBLE_ROUNDS = 10;
  localparam int ROUND_W       = $clog2(DOUBLE_ROUNDS + 1);
  localparam int HEAD_WORDS    = 12;

  localparam logic [WORD_W-1:0] POWER_ON_WORDS [WORD_COUNT] = '{
    32'h629102ea, 32'h4975d940, 32'h5f38e808, 32'h93dc408e,
    32'h0310d8a7, 32'h13dfd36a, 32'hf231d746, 32'h6c55e3f6,
    32'h3d5fb58f, 32'h18a6688d, 32'hce961cbc, 32'hbfab9c86,
    32'h366766b1, 32'hcd5856e8, 32'hdb0c3687, 32'h82a27f5e
  };

  localparam logic [WORD_W-1:0] RESEED_HEAD [HEAD_WORDS] = '{
    32'h61707865, 32'h3320646e, 32'h79622d32, 32'h6b206574,
    32'h344cbe69, 32'he549fedf, 32'h3606ae57, 32'hf8b072f2,
    32'h3c98c18b, 32'he50c7103, 32'he9753b30, 32'h82b37384
  };

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load_seed;
    logic       load_work;
    logic       qr_en;
    logic [1:0] qr_step;
    logic       qr_diag;
    logic       finish;
    logic       draw;
  } cc20rng_cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic exhausted;
  } cc20rng_stat_t;

endpackage

/* rtl/core/chacha20_feedback_random_generator_unit.sv */
// Top level of the ChaCha20 feedback random generator.
// A draw with words left keeps busy low and puts its item out in the cycle after acceptance.
// A draw that finds all sixteen words used stays busy through a refill (copy, 8 * DOUBLE_ROUNDS
// quarter-round steps with four shared lanes, feed-forward add, draw); item in the cycle after.
// A reseed refills without a draw and gives no item; the receiver can never stall the output.
// Synchronous active-low reset loads the built-in seed table and a read index of zero.
module chacha20_feedback_random_generator_unit
  import cc20rng_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic              in_op,
  input  logic [WORD_W-1:0] in_seed_value,
  output logic              out_valid,
  output logic [OUT_W-1:0]  out_random_value
);

  // The controller owns sequencing; the datapath owns all words and the read index.
  cc20rng_cmd_t  cmd;
  cc20rng_stat_t stat;

  cc20rng_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .op    (in_op),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  // The seed is sampled in the acceptance cycle, when the controller issues the load.
  cc20rng_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .seed_value       (in_seed_value),
    .stat             (stat),
    .out_valid        (out_valid),
    .out_random_value (out_random_value)
  );

endmodule

/* rtl/core/cc20rng_dp.sv */
// Datapath: block state, working copy, four quarter-round lanes and output register.
module cc20rng_dp
  import cc20rng_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  cc20rng_cmd_t        cmd,
  input  logic [WORD_W-1:0]   seed_value,
  output cc20rng_stat_t       stat,
  output logic                out_valid,
  output logic [OUT_W-1:0]    out_random_value
);

  logic [WORD_W-1:0] state_r [WORD_COUNT];
  logic [WORD_W-1:0] work_r  [WORD_COUNT];
  logic [WORD_W-1:0] work_nxt [WORD_COUNT];
  logic [POS_W-1:0]  pos_r;
  logic              valid_r;
  logic [OUT_W-1:0]  value_r;

  function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] v,
                                             input logic [4:0] n);
    return (v << n) | (v >> (6'd32 - {1'b0, n}));
  endfunction

  // One add/xor/rotate step of the quarter round on all four lanes.
  always_comb begin
    logic [1:0]        li;
    logic [IDX_W-1:0]  ia, ib, ic, id;
    logic [WORD_W-1:0] sum;
    work_nxt = work_r;
    for (int i = 0; i < 4; i++) begin
      li  = 2'(i);
      ia  = {2'b00, li};
      ib  = {2'b01, cmd.qr_diag ? li + 2'd1 : li};
      ic  = {2'b10, cmd.qr_diag ? li + 2'd2 : li};
      id  = {2'b11, cmd.qr_diag ? li + 2'd3 : li};
      sum = '0;
      case (cmd.qr_step)
        2'd0: begin
          sum          = work_r[ia] + work_r[ib];
          work_nxt[ia] = sum;
          work_nxt[id] = rotl(work_r[id] ^ sum, 5'd16);
        end
        2'd1: begin
          sum          = work_r[ic] + work_r[id];
          work_nxt[ic] = sum;
          work_nxt[ib] = rotl(work_r[ib] ^ sum, 5'd12);
        end
        2'd2: begin
          sum          = work_r[ia] + work_r[ib];
          work_nxt[ia] = sum;
          work_nxt[id] = rotl(work_r[id] ^ sum, 5'd8);
        end
        default: begin
          sum          = work_r[ic] + work_r[id];
          work_nxt[ic] = sum;
          work_nxt[ib] = rotl(work_r[ib] ^ sum, 5'd7);
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= POWER_ON_WORDS;
      pos_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      valid_r <= cmd.draw;
      if (cmd.load_seed) begin
        for (int k = 0; k < HEAD_WORDS; k++) begin
          state_r[k] <= RESEED_HEAD[k];
        end
        state_r[12] <= '0;
        state_r[13] <= '0;
        state_r[14] <= seed_value;
        state_r[15] <= seed_value;
      end else if (cmd.finish) begin
        for (int k = 0; k < WORD_COUNT; k++) begin
          state_r[k] <= work_r[k] + state_r[k];
        end
        pos_r <= '0;
      end else if (cmd.draw) begin
        pos_r <= pos_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_work) begin
      work_r <= state_r;
    end else if (cmd.qr_en) begin
      work_r <= work_nxt;
    end
    if (cmd.draw) begin
      value_r <= state_r[pos_r[IDX_W-1:0]][OUT_W-1:0];
    end
  end

  assign stat.exhausted   = pos_r[POS_W-1];
  assign out_valid        = valid_r;
  assign out_random_value = value_r;

endmodule

/* rtl/core/cc20rng_ctrl.sv */
// Controller: sequences reseed, block refill rounds and draws.
module cc20rng_ctrl
  import cc20rng_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic          op,
  input  cc20rng_stat_t stat,
  output cc20rng_cmd_t  cmd,
  output logic          busy
);

  typedef enum logic [2:0] {
    S_IDLE, S_PREP, S_ROUND, S_FINISH, S_DRAW
  } state_t;

  state_t             state_r, state_nxt;
  logic [1:0]         step_r, step_nxt;
  logic               diag_r, diag_nxt;
  logic [ROUND_W-1:0] round_r, round_nxt;
  logic               pend_r, pend_nxt;

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    diag_nxt  = diag_r;
    round_nxt = round_r;
    pend_nxt  = pend_r;
    cmd       = '0;
    cmd.qr_step = step_r;
    cmd.qr_diag = diag_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          if (op) begin
            cmd.load_seed = 1'b1;
            pend_nxt      = 1'b0;
            state_nxt     = S_PREP;
          end else if (stat.exhausted) begin
            pend_nxt  = 1'b1;
            state_nxt = S_PREP;
          end else begin
            cmd.draw = 1'b1;
          end
        end
      end
      S_PREP: begin
        cmd.load_work = 1'b1;
        step_nxt      = '0;
        diag_nxt      = 1'b0;
        round_nxt     = '0;
        state_nxt     = S_ROUND;
      end
      S_ROUND: begin
        cmd.qr_en = 1'b1;
        step_nxt  = step_r + 2'd1;
        if (step_r == 2'd3) begin
          diag_nxt = ~diag_r;
          if (diag_r) begin
            round_nxt = round_r + 1'b1;
            if (round_r == ROUND_W'(DOUBLE_ROUNDS - 1)) begin
              state_nxt = S_FINISH;
            end
          end
        end
      end
      S_FINISH: begin
        cmd.finish = 1'b1;
        state_nxt  = pend_r ? S_DRAW : S_IDLE;
      end
      S_DRAW: begin
        cmd.draw  = 1'b1;
        pend_nxt  = 1'b0;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
      diag_r  <= 1'b0;
      round_r <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      diag_r  <= diag_nxt;
      round_r <= round_nxt;
      pend_r  <= pend_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule
